// ===== design/bst_pkg.sv =====
// Shared types and constants for the byte-set tokenizer.
package bst_pkg;

  localparam int OFS_W = 16;

  // Configuration register indexes
  localparam logic [3:0] CFG_SEP_0   = 4'd0;
  localparam logic [3:0] CFG_SEP_3   = 4'd3;
  localparam logic [3:0] CFG_STRIP_0 = 4'd4;
  localparam logic [3:0] CFG_STRIP_3 = 4'd7;

  // Input commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic             token_valid;
    logic [OFS_W-1:0] token_start;
    logic [OFS_W-1:0] token_length;
    logic             token_last;
    logic             overflow;
  } out_item_t;

  // Classified byte handed from front to back
  typedef struct packed {
    logic is_end;
    logic is_sep;
    logic is_keep;
  } cls_t;

endpackage

// ===== design/bst_front.sv =====
// Front end: set registers, byte classification against separator and strip sets.
module bst_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [3:0]       cfg_index,
  input  logic [63:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  bst_pkg::in_item_t in_data,
  output logic             cls_valid,
  input  logic             cls_ready,
  output bst_pkg::cls_t    cls
);
  import bst_pkg::*;

  logic [3:0][63:0] sep_r, sep_nxt;
  logic [3:0][63:0] strip_r, strip_nxt;
  logic             in_sep, in_strip;

  always_comb begin
    sep_nxt   = sep_r;
    strip_nxt = strip_r;
    if (cfg_we) begin
      case (cfg_index) inside
        [CFG_SEP_0:CFG_SEP_3]:     sep_nxt[cfg_index[1:0]]   = cfg_data;
        [CFG_STRIP_0:CFG_STRIP_3]: strip_nxt[cfg_index[1:0]] = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r   <= '0;
      strip_r <= '0;
    end else begin
      sep_r   <= sep_nxt;
      strip_r <= strip_nxt;
    end
  end

  assign in_sep   = sep_r[in_data.data_byte[7:6]][in_data.data_byte[5:0]];
  assign in_strip = strip_r[in_data.data_byte[7:6]][in_data.data_byte[5:0]];

  // a byte in both sets acts as a separator
  always_comb begin
    cls.is_end  = (in_data.command == CMD_END);
    cls.is_sep  = (in_data.command == CMD_BYTE) && in_sep;
    cls.is_keep = (in_data.command == CMD_BYTE) && !in_sep && !in_strip;
  end

  assign cls_valid = in_valid;
  assign in_ready  = cls_ready;

endmodule

// ===== design/bst_fifo.sv =====
// Short queue of classified bytes between front and back.
module bst_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  bst_pkg::cls_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output bst_pkg::cls_t rd_data
);
  import bst_pkg::*;

  cls_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               push, pop;

  assign wr_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

// ===== design/bst_back.sv =====
// Back end: per-string token state and the registered result stage.
module bst_back #(
  parameter logic [15:0] OFS_LIMIT = 16'hFFFF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  bst_pkg::cls_t     q_data,
  output logic              out_valid,
  input  logic              out_ready,
  output bst_pkg::out_item_t out_data
);
  import bst_pkg::*;

  logic [OFS_W-1:0] pos_r, pos_nxt;
  logic [OFS_W-1:0] first_kept_r, first_kept_nxt;
  logic [OFS_W-1:0] kept_end_r, kept_end_nxt;
  logic             kept_seen_r, kept_seen_nxt;
  logic             sep_seen_r, sep_seen_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r, res;
  logic             emit, take, at_limit;
  logic [OFS_W-1:0] p, p_inc, tok_start, tok_len, seg_end;

  assign q_ready = !out_valid_r || out_ready;
  assign take    = q_valid && q_ready;

  assign at_limit = (pos_r >= OFS_LIMIT);
  assign p        = at_limit ? OFS_LIMIT : pos_r;
  assign p_inc    = (p < OFS_LIMIT) ? p + 1'b1 : OFS_LIMIT;
  assign seg_end  = q_data.is_end ? pos_r : p;

  always_comb begin
    if (kept_seen_r) begin
      tok_start = first_kept_r;
      tok_len   = (kept_end_r >= first_kept_r) ? kept_end_r - first_kept_r : '0;
    end else begin
      tok_start = seg_end;
      tok_len   = '0;
    end
  end

  always_comb begin
    pos_nxt        = pos_r;
    first_kept_nxt = first_kept_r;
    kept_end_nxt   = kept_end_r;
    kept_seen_nxt  = kept_seen_r;
    sep_seen_nxt   = sep_seen_r;
    ovf_nxt        = ovf_r;
    emit           = 1'b0;
    res            = '0;
    if (q_data.is_end) begin
      emit             = 1'b1;
      res.token_valid  = sep_seen_r || (tok_len != '0);
      res.token_start  = res.token_valid ? tok_start : '0;
      res.token_length = res.token_valid ? tok_len : '0;
      res.token_last   = 1'b1;
      res.overflow     = ovf_r;
      pos_nxt          = '0;
      first_kept_nxt   = '0;
      kept_end_nxt     = '0;
      kept_seen_nxt    = 1'b0;
      sep_seen_nxt     = 1'b0;
      ovf_nxt          = 1'b0;
    end else begin
      ovf_nxt = ovf_r || at_limit;
      pos_nxt = p_inc;
      if (q_data.is_sep) begin
        emit             = 1'b1;
        res.token_valid  = 1'b1;
        res.token_start  = tok_start;
        res.token_length = tok_len;
        res.token_last   = 1'b0;
        res.overflow     = ovf_nxt;
        kept_seen_nxt    = 1'b0;
        first_kept_nxt   = '0;
        kept_end_nxt     = '0;
        sep_seen_nxt     = 1'b1;
      end else if (q_data.is_keep) begin
        if (!kept_seen_r) begin
          kept_seen_nxt  = 1'b1;
          first_kept_nxt = p;
        end
        kept_end_nxt = p_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      first_kept_r <= '0;
      kept_end_r   <= '0;
      kept_seen_r  <= 1'b0;
      sep_seen_r   <= 1'b0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (take) begin
        pos_r        <= pos_nxt;
        first_kept_r <= first_kept_nxt;
        kept_end_r   <= kept_end_nxt;
        kept_seen_r  <= kept_seen_nxt;
        sep_seen_r   <= sep_seen_nxt;
        ovf_r        <= ovf_nxt;
      end
      if (q_ready) out_valid_r <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/byte_set_tokenizer_with_strip.sv =====
// Top level of the byte-set tokenizer with strip.
// Splits a byte stream at any byte of a 256-entry separator set and trims bytes
// of a 256-entry strip set from both ends of each token. One byte or end command
// is taken per cycle while the output is not stalled; a result is presented on the
// output once its queue entry has been read and the output register loaded, and
// the rate is set by the back end's token state update. Sets are loaded through
// eight 64-bit registers (separators at indexes 0-3, strip at 4-7); the user must
// load them only while the block is idle, which the block does not enforce.
// Offsets saturate at min(MAX_STRING_LEN, 65535) and set the overflow flag.
module byte_set_tokenizer_with_strip #(
  parameter longint unsigned MAX_STRING_LEN = 65535
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  bst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bst_pkg::out_item_t out_data
);
  import bst_pkg::*;

  localparam logic [15:0] OfsLimit =
    (MAX_STRING_LEN < 64'd65535) ? 16'(MAX_STRING_LEN) : 16'hFFFF;

  logic cls_valid, cls_ready, q_valid, q_ready;
  cls_t cls, q_data;

  bst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls       (cls)
  );

  bst_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cls_valid),
    .wr_ready (cls_ready),
    .wr_data  (cls),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  bst_back #(
    .OFS_LIMIT (OfsLimit)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/bst_checker.sv =====
// Port-level checks for the tokenizer, bound to the top level.
module bst_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input bst_pkg::out_item_t out_data
);
  import bst_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a dropped token only comes from the end command and carries zeros
  a_drop_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.token_valid |->
      out_data.token_last && out_data.token_start == '0 && out_data.token_length == '0)
    else $error("malformed dropped token");

  // separator results are always reported
  a_sep_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.token_last |-> out_data.token_valid)
    else $error("separator result marked not valid");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind byte_set_tokenizer_with_strip bst_checker u_bst_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
